// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LSW_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define LSW_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle assertion failed");

`endif

// ===== rtl/core/lsw_pkg.sv =====
// ----------------------------------------------------------------------------
// lsw_pkg
// Types, register codes and constants of the sector wall-follow steering core.
// ----------------------------------------------------------------------------
package lsw_pkg;

	localparam int QUEUE_DEPTH = 2;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 14;
	localparam int LIMIT_W     = 14;
	localparam int DEG_W       = 9;
	localparam int RANGE_W     = 16;
	localparam int DUTY_W      = 10;
	localparam int ANGLE_W     = 18;

	localparam logic [RANGE_W-1:0] NO_POINT    = 16'hFFFF;
	localparam logic [RANGE_W-1:0] FAR_READ_Q  = 16'd40000;
	localparam logic [LIMIT_W-1:0] NO_POINT_MM = 14'd10000;

	localparam logic signed [ANGLE_W-1:0] FRAME_ZERO = 18'sd5760;
	localparam logic signed [ANGLE_W-1:0] FULL_TURN  = 18'sd23040;

	localparam logic [DUTY_W-1:0] VEER_LEFT_L  = 10'd450;
	localparam logic [DUTY_W-1:0] VEER_LEFT_R  = 10'd500;
	localparam logic [DUTY_W-1:0] SPIN_DUTY    = 10'd250;
	localparam logic [DUTY_W-1:0] VEER_RIGHT_L = 10'd600;
	localparam logic [DUTY_W-1:0] VEER_RIGHT_R = 10'd350;

	localparam logic [LIMIT_W-1:0] NEAR_RESET   = 14'd250;
	localparam logic [LIMIT_W-1:0] FAR_RESET    = 14'd9000;
	localparam logic [DEG_W-1:0]   SIDE_LO_RST  = 9'd35;
	localparam logic [DEG_W-1:0]   SIDE_HI_RST  = 9'd90;
	localparam logic [DEG_W-1:0]   FRONT_LO_RST = 9'd75;
	localparam logic [DEG_W-1:0]   FRONT_HI_RST = 9'd100;
	localparam logic [DEG_W-1:0]   OFFSET_RST   = 9'd10;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_NEAR_LIMIT   = 3'd0,
		REG_FAR_LIMIT    = 3'd1,
		REG_SIDE_LOW     = 3'd2,
		REG_SIDE_HIGH    = 3'd3,
		REG_FRONT_LOW    = 3'd4,
		REG_FRONT_HIGH   = 3'd5,
		REG_MOUNT_OFFSET = 3'd6
	} lsw_reg_t;

	typedef enum logic [1:0] {
		STEER_VEER_LEFT  = 2'd0,
		STEER_SPIN_LEFT  = 2'd1,
		STEER_VEER_RIGHT = 2'd2
	} lsw_steer_t;

	typedef struct packed {
		logic [LIMIT_W-1:0] near_limit;
		logic [LIMIT_W-1:0] far_limit;
		logic [DEG_W-1:0]   side_low;
		logic [DEG_W-1:0]   side_high;
		logic [DEG_W-1:0]   front_low;
		logic [DEG_W-1:0]   front_high;
		logic [DEG_W-1:0]   mount_offset;
	} lsw_cfg_t;

	typedef struct packed {
		logic [RANGE_W-1:0] range;
		logic               in_side;
		logic               in_front;
		logic               eos;
	} lsw_meas_t;

	typedef struct packed {
		logic empty;
		logic full;
	} lsw_queue_stat_t;

	typedef struct packed {
		logic pop;
		logic pop_eos;
		logic minima_clear;
	} lsw_back_stat_t;

endpackage

// ===== rtl/core/lsw_queue.sv =====
// ----------------------------------------------------------------------------
// lsw_queue
// Short first-in first-out queue of classified items between front and back.
// ----------------------------------------------------------------------------
module lsw_queue #(
	parameter int DEPTH = lsw_pkg::QUEUE_DEPTH
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	input  lsw_pkg::lsw_meas_t        push_item,
	input  logic                      pop,
	output lsw_pkg::lsw_meas_t        head,
	output lsw_pkg::lsw_queue_stat_t  stat
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	lsw_pkg::lsw_meas_t entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign head       = entry_q[rd_ptr_q];
	assign stat.empty = (count_q == '0);
	assign stat.full  = (count_q == CNT_W'(DEPTH));

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/core/lsw_front.sv =====
// ----------------------------------------------------------------------------
// lsw_front
// Turns a raw measurement into robot-frame sector hits for the back end.
// ----------------------------------------------------------------------------
module lsw_front (
	input  lsw_pkg::lsw_cfg_t                 cfg,
	input  logic [7:0]                        quality_byte,
	input  logic [15:0]                       angle_raw,
	input  logic [lsw_pkg::RANGE_W-1:0]       range_quarter_mm,
	input  logic                              end_of_scan,
	output lsw_pkg::lsw_meas_t                meas
);

	logic                                usable;
	logic [16:0]                         raw_sum;
	logic signed [lsw_pkg::ANGLE_W-1:0]  t_raw;
	logic signed [lsw_pkg::ANGLE_W-1:0]  t_frame;
	logic signed [lsw_pkg::ANGLE_W-1:0]  side_lo;
	logic signed [lsw_pkg::ANGLE_W-1:0]  side_hi;
	logic signed [lsw_pkg::ANGLE_W-1:0]  front_lo;
	logic signed [lsw_pkg::ANGLE_W-1:0]  front_hi;

	always_comb begin
		usable   = (quality_byte[7:2] != '0) && (range_quarter_mm < lsw_pkg::FAR_READ_Q);
		raw_sum  = 17'(angle_raw[15:1]) + 17'({cfg.mount_offset, 6'b0});
		t_raw    = lsw_pkg::FRAME_ZERO - $signed({1'b0, raw_sum});
		t_frame  = (t_raw < 0) ? t_raw + lsw_pkg::FULL_TURN : t_raw;
		side_lo  = $signed(lsw_pkg::ANGLE_W'({cfg.side_low, 6'b0}));
		side_hi  = $signed(lsw_pkg::ANGLE_W'({cfg.side_high, 6'b0}));
		front_lo = $signed(lsw_pkg::ANGLE_W'({cfg.front_low, 6'b0}));
		front_hi = $signed(lsw_pkg::ANGLE_W'({cfg.front_high, 6'b0}));

		meas.range    = range_quarter_mm;
		meas.in_side  = usable && (side_lo < t_frame) && (t_frame < side_hi);
		meas.in_front = usable && (front_lo < t_frame) && (t_frame < front_hi);
		meas.eos      = end_of_scan;
	end

endmodule

// ===== rtl/core/lsw_back.sv =====
// ----------------------------------------------------------------------------
// lsw_back
// Keeps the sector minima and issues a steering decision at the end of a scan.
// ----------------------------------------------------------------------------
module lsw_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  lsw_pkg::lsw_cfg_t              cfg,
	input  lsw_pkg::lsw_meas_t             head,
	input  logic                           head_valid,
	output logic                           pop,
	output lsw_pkg::lsw_back_stat_t        stat,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           left_dir,
	output logic                           right_dir,
	output logic [lsw_pkg::DUTY_W-1:0]     left_duty,
	output logic [lsw_pkg::DUTY_W-1:0]     right_duty,
	output logic [1:0]                     steer_choice
);

	logic [lsw_pkg::RANGE_W-1:0] side_min_q;
	logic [lsw_pkg::RANGE_W-1:0] front_min_q;
	logic [lsw_pkg::RANGE_W-1:0] side_next;
	logic [lsw_pkg::RANGE_W-1:0] front_next;
	logic [lsw_pkg::RANGE_W-1:0] near_q4;
	logic [lsw_pkg::RANGE_W-1:0] far_q4;
	logic                        empty_wall;
	logic                        side_wall;
	logic                        front_wall;
	lsw_pkg::lsw_steer_t         choice;

	logic                        out_valid_q;
	logic                        left_dir_q;
	logic [lsw_pkg::DUTY_W-1:0]  left_duty_q;
	logic [lsw_pkg::DUTY_W-1:0]  right_duty_q;
	lsw_pkg::lsw_steer_t         choice_q;

	always_comb begin
		pop = head_valid && (!head.eos || !out_valid_q || out_ready);

		side_next  = (head.in_side && (head.range < side_min_q)) ? head.range : side_min_q;
		front_next = (head.in_front && (head.range < front_min_q)) ? head.range : front_min_q;

		near_q4    = {cfg.near_limit, 2'b0};
		far_q4     = {cfg.far_limit, 2'b0};
		empty_wall = (cfg.near_limit >= lsw_pkg::NO_POINT_MM) ||
			(cfg.far_limit < lsw_pkg::NO_POINT_MM);
		side_wall  = (side_next == lsw_pkg::NO_POINT) ? empty_wall :
			((side_next < near_q4) || (side_next > far_q4));
		front_wall = (front_next == lsw_pkg::NO_POINT) ? empty_wall :
			((front_next < near_q4) || (front_next > far_q4));

		if (side_wall && !front_wall) begin
			choice = lsw_pkg::STEER_VEER_LEFT;
		end else if (front_wall) begin
			choice = lsw_pkg::STEER_SPIN_LEFT;
		end else begin
			choice = lsw_pkg::STEER_VEER_RIGHT;
		end

		stat.pop          = pop;
		stat.pop_eos      = pop && head.eos;
		stat.minima_clear = (side_min_q == lsw_pkg::NO_POINT) &&
			(front_min_q == lsw_pkg::NO_POINT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_min_q  <= lsw_pkg::NO_POINT;
			front_min_q <= lsw_pkg::NO_POINT;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				side_min_q  <= head.eos ? lsw_pkg::NO_POINT : side_next;
				front_min_q <= head.eos ? lsw_pkg::NO_POINT : front_next;
			end
			if (pop && head.eos) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && head.eos) begin
			choice_q <= choice;
			unique case (choice)
				lsw_pkg::STEER_VEER_LEFT: begin
					left_dir_q   <= 1'b1;
					left_duty_q  <= lsw_pkg::VEER_LEFT_L;
					right_duty_q <= lsw_pkg::VEER_LEFT_R;
				end
				lsw_pkg::STEER_SPIN_LEFT: begin
					left_dir_q   <= 1'b0;
					left_duty_q  <= lsw_pkg::SPIN_DUTY;
					right_duty_q <= lsw_pkg::SPIN_DUTY;
				end
				default: begin
					left_dir_q   <= 1'b1;
					left_duty_q  <= lsw_pkg::VEER_RIGHT_L;
					right_duty_q <= lsw_pkg::VEER_RIGHT_R;
				end
			endcase
		end
	end

	// The right wheel never runs backwards in any of the three manoeuvres.
	assign right_dir    = 1'b0;
	assign out_valid    = out_valid_q;
	assign left_dir     = left_dir_q;
	assign left_duty    = left_duty_q;
	assign right_duty   = right_duty_q;
	assign steer_choice = choice_q;

endmodule

// ===== rtl/core/lidar_sector_wall_follow_steer_core.sv =====
// ----------------------------------------------------------------------------
// lidar_sector_wall_follow_steer_core
// Wall-following steering from a stream of scan measurements.
// ----------------------------------------------------------------------------
// Each item is one scan measurement; the core accepts one item per clock while
// in_ready is high. The classifying front end writes the queue at the accepting
// edge; the minimum-tracking back end, whose single compare-and-update per item
// sets the rate, pops the end-of-scan item from the queue and registers the
// decision, which is then offered on out_valid. A two-entry queue lets the
// front keep taking items while a finished result waits on out_ready; the next
// end-of-scan item is held back until the previous result is taken, and the
// input stalls once the queue behind it fills.
`include "assert_macros.svh"

module lidar_sector_wall_follow_steer_core #(
	parameter int QUEUE_DEPTH = lsw_pkg::QUEUE_DEPTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [lsw_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [lsw_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [7:0]                        quality_byte,
	input  logic [15:0]                       angle_raw,
	input  logic [15:0]                       range_quarter_mm,
	input  logic                              end_of_scan,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              left_dir,
	output logic                              right_dir,
	output logic [9:0]                        left_duty,
	output logic [9:0]                        right_duty,
	output logic [1:0]                        steer_choice
);

	lsw_pkg::lsw_cfg_t        cfg_q;
	lsw_pkg::lsw_meas_t       meas;
	lsw_pkg::lsw_meas_t       head;
	lsw_pkg::lsw_queue_stat_t qstat;
	lsw_pkg::lsw_back_stat_t  bstat;
	logic                     push;
	logic                     pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.near_limit   <= lsw_pkg::NEAR_RESET;
			cfg_q.far_limit    <= lsw_pkg::FAR_RESET;
			cfg_q.side_low     <= lsw_pkg::SIDE_LO_RST;
			cfg_q.side_high    <= lsw_pkg::SIDE_HI_RST;
			cfg_q.front_low    <= lsw_pkg::FRONT_LO_RST;
			cfg_q.front_high   <= lsw_pkg::FRONT_HI_RST;
			cfg_q.mount_offset <= lsw_pkg::OFFSET_RST;
		end else if (cfg_we) begin
			unique case (lsw_pkg::lsw_reg_t'(cfg_index))
				lsw_pkg::REG_NEAR_LIMIT:   cfg_q.near_limit   <= cfg_data;
				lsw_pkg::REG_FAR_LIMIT:    cfg_q.far_limit    <= cfg_data;
				lsw_pkg::REG_SIDE_LOW:     cfg_q.side_low     <= cfg_data[lsw_pkg::DEG_W-1:0];
				lsw_pkg::REG_SIDE_HIGH:    cfg_q.side_high    <= cfg_data[lsw_pkg::DEG_W-1:0];
				lsw_pkg::REG_FRONT_LOW:    cfg_q.front_low    <= cfg_data[lsw_pkg::DEG_W-1:0];
				lsw_pkg::REG_FRONT_HIGH:   cfg_q.front_high   <= cfg_data[lsw_pkg::DEG_W-1:0];
				lsw_pkg::REG_MOUNT_OFFSET: cfg_q.mount_offset <= cfg_data[lsw_pkg::DEG_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign in_ready = !qstat.full;
	assign push     = in_valid && in_ready;

	lsw_front u_front (
		.cfg              (cfg_q),
		.quality_byte     (quality_byte),
		.angle_raw        (angle_raw),
		.range_quarter_mm (range_quarter_mm),
		.end_of_scan      (end_of_scan),
		.meas             (meas)
	);

	lsw_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (meas),
		.pop       (pop),
		.head      (head),
		.stat      (qstat)
	);

	lsw_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.head         (head),
		.head_valid   (!qstat.empty),
		.pop          (pop),
		.stat         (bstat),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.left_dir     (left_dir),
		.right_dir    (right_dir),
		.left_duty    (left_duty),
		.right_duty   (right_duty),
		.steer_choice (steer_choice)
	);

	`LSW_ASSERT_SAME(a_pop_needs_item, bstat.pop, !qstat.empty)
	`LSW_ASSERT_NEXT(a_eos_gives_result, bstat.pop_eos, out_valid)
	`LSW_ASSERT_NEXT(a_eos_clears_minima, bstat.pop_eos, bstat.minima_clear)

endmodule
